// File: rtl/core/plat_pkg.sv
// Shared types, constants and tables for the platform leg length solver.
// No dependencies; all other files but plat_ram use it by scoped names.
package plat_pkg;

    localparam int NUM_LEGS   = 6;
    localparam int NUM_JOINTS = 3 * NUM_LEGS;
    localparam int ADDR_W     = $clog2(NUM_JOINTS);
    localparam int LEG_W      = 3;
    localparam int WORD_W     = 32;
    localparam int Z_W        = 36;   // CORDIC angle accumulator
    localparam int XY_W       = 34;   // sin/cos and Q30 products
    localparam int OP_W       = 35;   // multiplier operand
    localparam int PROD_W     = 2 * OP_W;
    localparam int ACC_W      = 68;   // dot product accumulator
    localparam int CMP_W      = ACC_W - 30;
    localparam int Q_SHIFT    = 30;
    localparam int NUM_QPROD  = 14;

    localparam logic signed [Z_W-1:0]  Q_PI      = 36'sd3373259426;
    localparam logic signed [Z_W-1:0]  Q_HALF_PI = 36'sd1686629713;
    localparam logic signed [Z_W-1:0]  Q_TWO_PI  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0] Q_GAIN    = 34'sd652032874;
    localparam logic [WORD_W-1:0]      LEN_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                   done;
        logic signed [XY_W-1:0] sin_v;
        logic signed [XY_W-1:0] cos_v;
    } t_cordic_res;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] root;
    } t_sqrt_res;

    // atan(2^-i) in Q30
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            5'd30: v = 36'sd1;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/plat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/plat_cordic.sv
// Iterative sin/cos: range reduction, then 32 rotation steps, one per cycle.
// Depends on plat_pkg.
module plat_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [plat_pkg::Z_W-1:0] i_ang,
    output plat_pkg::t_cordic_res           o_res
);
    logic                             r_red;
    logic                             r_it;
    logic                             r_done;
    logic                             r_neg;
    logic [4:0]                       r_i;
    logic signed [plat_pkg::XY_W-1:0] r_x;
    logic signed [plat_pkg::XY_W-1:0] r_y;
    logic signed [plat_pkg::Z_W-1:0]  r_z;
    logic signed [plat_pkg::XY_W-1:0] w_dx;
    logic signed [plat_pkg::XY_W-1:0] w_dy;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red  <= 1'b0;
            r_it   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_z   <= i_ang;
                r_red <= 1'b1;
                r_it  <= 1'b0;
                r_neg <= 1'b0;
                r_x   <= plat_pkg::Q_GAIN;
                r_y   <= '0;
                r_i   <= '0;
            end else if (r_red) begin
                if (r_z > plat_pkg::Q_PI) begin
                    r_z <= r_z - plat_pkg::Q_TWO_PI;
                end else if (r_z < -plat_pkg::Q_PI) begin
                    r_z <= r_z + plat_pkg::Q_TWO_PI;
                end else begin
                    r_red <= 1'b0;
                    r_it  <= 1'b1;
                    // fold into the right half plane, flip signs at the end
                    if (r_z > plat_pkg::Q_HALF_PI) begin
                        r_z   <= r_z - plat_pkg::Q_PI;
                        r_neg <= 1'b1;
                    end else if (r_z < -plat_pkg::Q_HALF_PI) begin
                        r_z   <= r_z + plat_pkg::Q_PI;
                        r_neg <= 1'b1;
                    end
                end
            end else if (r_it) begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - plat_pkg::atan_q30(r_i);
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + plat_pkg::atan_q30(r_i);
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'd31) begin
                    r_it   <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.sin_v = r_neg ? -r_y : r_y;
    assign o_res.cos_v = r_neg ? -r_x : r_x;
endmodule

// File: rtl/core/plat_sqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on plat_pkg.
module plat_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_val,
    output plat_pkg::t_sqrt_res o_res
);
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= i_val;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_n >= w_trial) begin
                    r_n   <= r_n - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_res[plat_pkg::WORD_W-1:0];
endmodule

// File: rtl/core/platform_leg_length_solver.sv
// Top level of the platform leg length solver: joint RAMs, CORDIC, square root,
// one shared multiplier and the sequencer. Depends on plat_pkg and all submodules.
// A load item writes its P and B joints to the RAMs. A pose does three CORDIC runs,
// then the rotation matrix, then per leg joint reads, 9 dot product terms and 3 squares
// on the shared multiplier, and a square root.
// One item at a time; ready is high only while idle. Results wait in an output register.
// Reset (synchronous, active low) clears control state; joint RAMs hold no reset value.
module platform_leg_length_solver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // leg_number[2:0], pos_x, pos_y, pos_z, second_a, second_b, second_c, zero pad
    input  logic [199:0] i_s_tdata,
    // action[0]
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_leg[2:0], leg_length[34:3], zero pad
    output logic [39:0]  o_m_tdata,
    // last_leg
    output logic         o_m_tlast
);
    localparam int XW = plat_pkg::XY_W;
    localparam int OW = plat_pkg::OP_W;
    localparam int WW = plat_pkg::WORD_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LOAD = 11'b000_0000_0010,
        S_ANG  = 11'b000_0000_0100,
        S_MAT  = 11'b000_0000_1000,
        S_RCMB = 11'b000_0001_0000,
        S_RD   = 11'b000_0010_0000,
        S_DOT  = 11'b000_0100_0000,
        S_CMP  = 11'b000_1000_0000,
        S_SQ   = 11'b001_0000_0000,
        S_ROOT = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state                        r_state;
    logic [3:0]                    r_cnt;
    logic [1:0]                    r_ang_idx;
    logic [1:0]                    r_j;
    logic [plat_pkg::LEG_W-1:0]    r_leg;      // leg of a load item
    logic [plat_pkg::LEG_W-1:0]    r_leg_i;    // leg being solved
    logic signed [WW-1:0]          r_pos [3];  // T, or P on load
    logic signed [WW-1:0]          r_sec [3];  // angles, or B on load
    logic signed [XW-1:0]          r_sin [3];
    logic signed [XW-1:0]          r_cos [3];
    logic signed [XW-1:0]          r_q   [plat_pkg::NUM_QPROD];
    logic signed [OW-1:0]          r_rm  [3][3];
    logic signed [WW-1:0]          r_p   [3];
    logic signed [WW-1:0]          r_b   [3];
    logic signed [plat_pkg::PROD_W-1:0] r_prod;
    logic signed [plat_pkg::ACC_W-1:0]  r_acc;
    logic [WW-1:0]                 r_mag;
    logic [63:0]                   r_sum;
    logic                          r_sat;
    logic                          r_cstart;
    logic                          r_rstart;
    logic [WW-1:0]                 r_len;
    logic                          r_ovalid;
    logic [plat_pkg::LEG_W-1:0]    r_oleg;
    logic [WW-1:0]                 r_olen;
    logic                          r_olast;

    logic signed [OW-1:0]          w_ma;
    logic signed [OW-1:0]          w_mb;
    logic [plat_pkg::ADDR_W-1:0]   w_addr;
    logic                          w_we;
    logic [WW-1:0]                 w_rd_p;
    logic [WW-1:0]                 w_rd_b;
    logic signed [plat_pkg::Z_W-1:0] w_ang;
    logic signed [XW-1:0]          w_qv;
    logic signed [plat_pkg::CMP_W-1:0] w_comp;
    logic [plat_pkg::CMP_W-1:0]    w_mag;
    logic [64:0]                   w_sum_nx;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_last_leg;
    plat_pkg::t_cordic_res         w_cres;
    plat_pkg::t_sqrt_res           w_sres;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_last_leg = (r_leg_i == plat_pkg::LEG_W'(plat_pkg::NUM_LEGS - 1));

    // joint address: 3*leg + axis
    always_comb begin
        if (r_state == S_LOAD) begin
            w_addr = plat_pkg::ADDR_W'(int'(r_leg) * 3 + int'(r_cnt[1:0]));
        end else begin
            w_addr = plat_pkg::ADDR_W'(int'(r_leg_i) * 3 + int'(r_cnt[1:0]));
        end
    end
    // out-of-range legs are dropped silently
    assign w_we = (r_state == S_LOAD) &&
                  ({1'b0, r_leg} < (plat_pkg::LEG_W + 1)'(plat_pkg::NUM_LEGS));

    plat_ram #(.WIDTH(WW), .DEPTH(plat_pkg::NUM_JOINTS)) u_ram_p (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (r_pos[r_cnt[1:0]]),
        .i_raddr (w_addr),
        .o_rdata (w_rd_p)
    );

    plat_ram #(.WIDTH(WW), .DEPTH(plat_pkg::NUM_JOINTS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (r_sec[r_cnt[1:0]]),
        .i_raddr (w_addr),
        .o_rdata (w_rd_b)
    );

    // angle widened to Q30
    assign w_ang = {{2{r_sec[r_ang_idx][WW-1]}}, r_sec[r_ang_idx], 2'b00};

    plat_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_ang   (w_ang),
        .o_res   (w_cres)
    );

    plat_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rstart),
        .i_val   (r_sum),
        .o_res   (w_sres)
    );

    // shared multiplier operand select
    // sa/ca = index 0, sb/cb = 1, sc/cc = 2
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MAT: begin
                case (r_cnt)
                    4'd0:  begin w_ma = OW'(r_sin[0]); w_mb = OW'(r_sin[1]); end
                    4'd1:  begin w_ma = OW'(r_cos[0]); w_mb = OW'(r_sin[1]); end
                    4'd2:  begin w_ma = OW'(r_cos[1]); w_mb = OW'(r_cos[2]); end
                    4'd3:  begin w_ma = OW'(r_cos[1]); w_mb = OW'(r_sin[2]); end
                    4'd4:  begin w_ma = OW'(r_q[0]);   w_mb = OW'(r_cos[2]); end
                    4'd5:  begin w_ma = OW'(r_cos[0]); w_mb = OW'(r_sin[2]); end
                    4'd6:  begin w_ma = OW'(r_cos[0]); w_mb = OW'(r_cos[2]); end
                    4'd7:  begin w_ma = OW'(r_q[0]);   w_mb = OW'(r_sin[2]); end
                    4'd8:  begin w_ma = OW'(r_sin[0]); w_mb = OW'(r_cos[1]); end
                    4'd9:  begin w_ma = OW'(r_sin[0]); w_mb = OW'(r_sin[2]); end
                    4'd10: begin w_ma = OW'(r_q[1]);   w_mb = OW'(r_cos[2]); end
                    4'd11: begin w_ma = OW'(r_q[1]);   w_mb = OW'(r_sin[2]); end
                    4'd12: begin w_ma = OW'(r_sin[0]); w_mb = OW'(r_cos[2]); end
                    4'd13: begin w_ma = OW'(r_cos[0]); w_mb = OW'(r_cos[1]); end
                    default: ;
                endcase
            end
            S_DOT: begin
                w_ma = r_rm[r_j][r_cnt[1:0]];
                w_mb = OW'(r_p[r_cnt[1:0]]);
            end
            S_SQ: begin
                w_ma = $signed({3'b000, r_mag});
                w_mb = $signed({3'b000, r_mag});
            end
            default: ;
        endcase
    end

    assign w_qv     = XW'(r_prod >>> plat_pkg::Q_SHIFT);
    assign w_comp   = plat_pkg::CMP_W'(r_acc >>> plat_pkg::Q_SHIFT)
                    + plat_pkg::CMP_W'(r_pos[r_j]) - plat_pkg::CMP_W'(r_b[r_j]);
    assign w_mag    = w_comp[plat_pkg::CMP_W-1] ? plat_pkg::CMP_W'(-w_comp)
                                                : plat_pkg::CMP_W'(w_comp);
    assign w_sum_nx = {1'b0, r_sum} + {1'b0, r_prod[63:0]};

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cstart <= 1'b0;
            r_rstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            r_rstart <= 1'b0;
            // S_OUT refills the output register itself
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_leg    <= i_s_tdata[2:0];
                        r_pos[0] <= i_s_tdata[34:3];
                        r_pos[1] <= i_s_tdata[66:35];
                        r_pos[2] <= i_s_tdata[98:67];
                        r_sec[0] <= i_s_tdata[130:99];
                        r_sec[1] <= i_s_tdata[162:131];
                        r_sec[2] <= i_s_tdata[194:163];
                        r_cnt    <= '0;
                        if (i_s_tuser[0]) begin
                            r_state   <= S_ANG;
                            r_ang_idx <= '0;
                            r_cstart  <= 1'b1;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd2) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ANG: begin
                    if (w_cres.done) begin
                        r_sin[r_ang_idx] <= w_cres.sin_v;
                        r_cos[r_ang_idx] <= w_cres.cos_v;
                        if (r_ang_idx == 2'd2) begin
                            r_state <= S_MAT;
                            r_cnt   <= '0;
                        end else begin
                            r_ang_idx <= r_ang_idx + 2'd1;
                            r_cstart  <= 1'b1;
                        end
                    end
                end
                S_MAT: begin
                    // issue product cnt, store product cnt-1
                    if (r_cnt != 4'd0) begin
                        r_q[r_cnt - 4'd1] <= w_qv;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(plat_pkg::NUM_QPROD)) begin
                        r_state <= S_RCMB;
                    end
                end
                S_RCMB: begin
                    r_rm[0][0] <= OW'(r_q[2]);
                    r_rm[0][1] <= -OW'(r_q[3]);
                    r_rm[0][2] <= OW'(r_sin[1]);
                    r_rm[1][0] <= OW'(r_q[4]) + OW'(r_q[5]);
                    r_rm[1][1] <= OW'(r_q[6]) - OW'(r_q[7]);
                    r_rm[1][2] <= -OW'(r_q[8]);
                    r_rm[2][0] <= OW'(r_q[9]) - OW'(r_q[10]);
                    r_rm[2][1] <= OW'(r_q[11]) + OW'(r_q[12]);
                    r_rm[2][2] <= OW'(r_q[13]);
                    r_leg_i    <= '0;
                    r_cnt      <= '0;
                    r_state    <= S_RD;
                end
                S_RD: begin
                    // three reads, data arriving in the cycle after its address
                    if (r_cnt != 4'd0) begin
                        r_p[r_cnt[1:0] - 2'd1] <= w_rd_p;
                        r_b[r_cnt[1:0] - 2'd1] <= w_rd_b;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        r_state <= S_DOT;
                        r_cnt   <= '0;
                        r_j     <= '0;
                        r_sum   <= '0;
                        r_sat   <= 1'b0;
                    end
                end
                S_DOT: begin
                    if (r_cnt == 4'd1) begin
                        r_acc <= plat_pkg::ACC_W'(r_prod);
                    end else if (r_cnt != 4'd0) begin
                        r_acc <= r_acc + plat_pkg::ACC_W'(r_prod);
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // component beyond 32 bits saturates the length
                    if (w_mag[plat_pkg::CMP_W-1:WW] != '0) begin
                        r_sat <= 1'b1;
                        r_mag <= '0;
                    end else begin
                        r_mag <= w_mag[WW-1:0];
                    end
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd1) begin
                        r_sum <= w_sum_nx[63:0];
                        if (w_sum_nx[64]) begin
                            r_sat <= 1'b1;
                        end
                        r_cnt <= '0;
                        if (r_j == 2'd2) begin
                            r_state  <= S_ROOT;
                            r_rstart <= 1'b1;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_DOT;
                        end
                    end
                end
                S_ROOT: begin
                    if (w_sres.done) begin
                        r_len   <= r_sat ? plat_pkg::LEN_MAX : w_sres.root;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oleg   <= r_leg_i;
                        r_olen   <= r_len;
                        r_olast  <= w_last_leg;
                        r_cnt    <= '0;
                        if (w_last_leg) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_leg_i <= r_leg_i + 3'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'b00000, r_olen, r_oleg};
    assign o_m_tlast  = r_olast;
endmodule

// File: rtl/core/plat_checker.sv
// Port-level checks for the platform leg length solver, bound to the top level.
// Depends on plat_pkg and platform_leg_length_solver.
module plat_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [199:0] i_s_tdata,
    input logic [0:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [39:0]  o_m_tdata,
    input logic         o_m_tlast
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_last_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[2:0] == 3'(plat_pkg::NUM_LEGS - 1))
        else $error("last flag on wrong leg");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready held after accept");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser[0] && !o_m_tvalid |=> !o_m_tvalid)
        else $error("load item produced a result");
endmodule

bind platform_leg_length_solver plat_checker u_plat_checker (.*);

// File: sim/platform_leg_length_solver_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for platform_leg_length_solver: directed joint loads and poses, then
// random poses and loads, each length checked against an integer-exact length predictor.
// Depends on plat_pkg and the solver RTL.
module platform_leg_length_solver_tb;

    localparam int    LEGS       = plat_pkg::NUM_LEGS;
    localparam int    STALL_MAX  = 16;
    localparam int    LONG_HOLD  = 1500;
    localparam int    DOG_LIMIT  = 20000;
    localparam int    N_RANDOM   = 410;
    localparam logic  ACT_LOAD   = 1'b0;
    localparam logic  ACT_POSE   = 1'b1;
    localparam longint PI_Q      = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint TWO_PI_Q  = 64'sd6746518852;
    localparam longint GAIN_Q    = 64'sd652032874;
    localparam longint ANG_QPI   = 843314856;   // about pi in input units (rad * 2^28)

    typedef struct packed {
        logic        act;
        logic [2:0]  leg;
        logic [31:0] px, py, pz, sa, sb, sc;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  leg;
        logic [31:0] len;
        logic        last;
    } t_len;

    logic         i_clk, i_rst_n;
    logic         i_s_tvalid, o_s_tready;
    logic [199:0] i_s_tdata;
    logic [0:0]   i_s_tuser;
    logic         o_m_tvalid, i_m_tready;
    logic [39:0]  o_m_tdata;
    logic         o_m_tlast;

    platform_leg_length_solver dut (.*);

    // predictor state: joint coordinates per leg and axis
    longint plat_xyz [LEGS][3];
    longint base_xyz [LEGS][3];
    t_len   len_queue[$];
    t_cmd   cmd_list [$];
    longint atan_tab [32];

    int  mismatches;
    int  watchdog;
    bit  src_done, hold_long;

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;   // arithmetic shift floors for signed longint
    endfunction

    function automatic longint qmul30(longint a, longint b);
        return floor_shift(a * b, 30);
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        x = GAIN_Q; y = 0; z = ang; flip = 0;
        while (z > PI_Q) z -= TWO_PI_Q;
        while (z < -PI_Q) z += TWO_PI_Q;
        if (z > HALF_PI_Q) begin
            z -= PI_Q; flip = 1;
        end else if (z < -HALF_PI_Q) begin
            z += PI_Q; flip = 1;
        end
        for (int i = 0; i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = 0; b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Applies one accepted item to the joint store, or queues six expected lengths.
    task automatic predict_legs(input t_cmd cmd);
        longint rot[3][3], tr[3];
        longint sa, ca, sb, cb, sc, cc, sasb, casb, acc, comp;
        logic [63:0] mag, sq, sum, root;
        bit     sat;
        t_len   r;
        if (cmd.act == ACT_LOAD) begin
            if (cmd.leg < LEGS) begin
                plat_xyz[cmd.leg] = '{longint'($signed(cmd.px)), longint'($signed(cmd.py)),
                                      longint'($signed(cmd.pz))};
                base_xyz[cmd.leg] = '{longint'($signed(cmd.sa)), longint'($signed(cmd.sb)),
                                      longint'($signed(cmd.sc))};
            end
            return;
        end
        tr = '{longint'($signed(cmd.px)), longint'($signed(cmd.py)), longint'($signed(cmd.pz))};
        cordic_sincos(longint'($signed(cmd.sa)) * 4, sa, ca);
        cordic_sincos(longint'($signed(cmd.sb)) * 4, sb, cb);
        cordic_sincos(longint'($signed(cmd.sc)) * 4, sc, cc);
        sasb = qmul30(sa, sb);
        casb = qmul30(ca, sb);
        rot[0][0] = qmul30(cb, cc);
        rot[0][1] = -qmul30(cb, sc);
        rot[0][2] = sb;
        rot[1][0] = qmul30(sasb, cc) + qmul30(ca, sc);
        rot[1][1] = qmul30(ca, cc) - qmul30(sasb, sc);
        rot[1][2] = -qmul30(sa, cb);
        rot[2][0] = qmul30(sa, sc) - qmul30(casb, cc);
        rot[2][1] = qmul30(casb, sc) + qmul30(sa, cc);
        rot[2][2] = qmul30(ca, cb);
        for (int i = 0; i < LEGS; i++) begin
            sum = 0; sat = 0;
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += rot[j][k] * plat_xyz[i][k];
                comp = floor_shift(acc, 30) + tr[j] - base_xyz[i][j];
                mag = comp < 0 ? -comp : comp;
                if (mag > 64'hFFFF_FFFF) begin
                    sat = 1;
                    continue;
                end
                sq = mag * mag;
                if (sum + sq < sum) sat = 1;
                sum += sq;
            end
            root   = int_sqrt(sum);
            r.leg  = i[2:0];
            r.len  = sat ? 32'hFFFF_FFFF : root[31:0];
            r.last = (i == LEGS - 1);
            len_queue.push_back(r);
        end
    endtask

    function automatic t_cmd mk(logic act, logic [2:0] leg, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [31:0] sa, logic [31:0] sb,
                                logic [31:0] sc);
        t_cmd c;
        c.act = act; c.leg = leg; c.px = px; c.py = py; c.pz = pz;
        c.sa = sa; c.sb = sb; c.sc = sc;
        return c;
    endfunction

    // random coordinate: mostly moderate, sometimes full range
    function automatic logic [31:0] rnd_coord();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 4000000)) - 2000000);
    endfunction

    function automatic logic [31:0] rnd_angle();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'(ANG_QPI / 2) + $urandom_range(0, 40) - 20;
            default: return 32'(longint'($urandom_range(0, 2 * ANG_QPI)) - ANG_QPI);
        endcase
    endfunction

    function automatic t_cmd rnd_load(logic [2:0] leg);
        return mk(ACT_LOAD, leg, rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_coord(), rnd_coord());
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Directed table, then random; all six legs are loaded before the first pose.
    task automatic build_stimulus();
        t_cmd c;
        // every leg loaded with zero joints: identity pose gives zero lengths
        for (int l = 0; l < LEGS; l++)
            cmd_list.push_back(mk(ACT_LOAD, 3'(l), 0, 0, 0, 0, 0, 0));
        cmd_list.push_back(mk(ACT_POSE, 3'd7, 0, 0, 0, 0, 0, 0));
        // extreme negative and positive translation along x
        cmd_list.push_back(mk(ACT_POSE, 3'd0, 32'h8000_0000, 0, 0, 0, 0, 0));
        cmd_list.push_back(mk(ACT_POSE, 3'd0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        // leg number out of range is ignored
        cmd_list.push_back(mk(ACT_LOAD, 3'd6, 32'h7FFF_FFFF, 1, 1, 1, 1, 1));
        cmd_list.push_back(mk(ACT_LOAD, 3'd7, 32'h8000_0000, 1, 1, 1, 1, 1));
        // extreme joints
        cmd_list.push_back(mk(ACT_LOAD, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF, 0));
        for (int l = 1; l < LEGS; l++) cmd_list.push_back(rnd_load(3'(l)));
        // angle wrap and half-pi folding, extreme angles
        cmd_list.push_back(mk(ACT_POSE, 3'd0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF));
        cmd_list.push_back(mk(ACT_POSE, 3'd0, 100, -100, 5000, 32'(ANG_QPI), 32'(-ANG_QPI),
                              32'(ANG_QPI / 2 + 1)));
        cmd_list.push_back(mk(ACT_POSE, 3'd0, 0, 0, 0, 32'(-ANG_QPI / 2 - 1), 32'(3 * ANG_QPI),
                              32'(-3 * ANG_QPI)));
        cmd_list.push_back(mk(ACT_POSE, 3'd0, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 1,
                              32'hFFFF_FFFF, 0));
        // random: mostly poses, with occasional joint reloads
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                c = rnd_load(3'($urandom_range(0, 7)));
            end else begin
                c = mk(ACT_POSE, 3'($urandom_range(0, 7)), rnd_coord(), rnd_coord(),
                       rnd_coord(), rnd_angle(), rnd_angle(), rnd_angle());
            end
            cmd_list.push_back(c);
        end
    endtask

    // Expected values typed in for the first poses (zero joints, identity or extreme shift).
    t_len known_q[$];

    // sender
    initial begin
        t_cmd c;
        int   gap;
        i_rst_n    <= 0;
        i_s_tvalid <= 0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        src_done   = 0;
        for (int i = 0; i < 32; i++) atan_tab[i] = plat_pkg::atan_q30(i[4:0]);
        for (int l = 0; l < LEGS; l++) begin
            plat_xyz[l] = '{0, 0, 0};
            base_xyz[l] = '{0, 0, 0};
        end
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        foreach (cmd_list[n]) begin
            c   = cmd_list[n];
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0) begin
                i_s_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1;
            i_s_tuser  <= c.act;
            i_s_tdata  <= {5'd0, c.sc, c.sb, c.sa, c.pz, c.py, c.px, c.leg};
            @(posedge i_clk iff o_s_tready);
            predict_legs(c);
        end
        i_s_tvalid <= 0;
        src_done = 1;
    end

    // directed expectations checked alongside the predictor
    initial begin
        for (int l = 0; l < LEGS; l++) known_q.push_back('{l[2:0], 32'd0, l == LEGS - 1});
        for (int l = 0; l < LEGS; l++) known_q.push_back('{l[2:0], 32'h8000_0000, l == LEGS - 1});
        for (int l = 0; l < LEGS; l++) known_q.push_back('{l[2:0], 32'h7FFF_FFFF, l == LEGS - 1});
    end

    // one long hold-off of the receiver while the sender keeps offering items
    initial begin
        hold_long = 0;
        wait (cmd_list.size() > 0 && i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_long = 1;
        for (int k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
        hold_long = 0;
    end

    // receiver and checker
    initial begin
        t_len got, want;
        int   gap;
        mismatches = 0;
        i_m_tready <= 0;
        wait (i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0 || hold_long) begin
                i_m_tready <= 0;
                repeat (gap) @(posedge i_clk);
                while (hold_long) @(posedge i_clk);
            end
            i_m_tready <= 1;
            @(posedge i_clk iff o_m_tvalid);
            got = '{o_m_tdata[2:0], o_m_tdata[34:3], o_m_tlast};
            if (len_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected leg length item: %p", got);
            end else begin
                want = len_queue.pop_front();
                if (known_q.size() > 0 && known_q.pop_front() != want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("predictor disagrees with typed value %p", want);
                end
                if (got.leg !== want.leg || got.len !== want.len || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("leg mismatch: exp leg %0d len %0d last %0b, got %0d %0d %0b",
                                 want.leg, want.len, want.last, got.leg, got.len, got.last);
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        watchdog = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || hold_long)
                watchdog = 0;
            else
                watchdog++;
            if (watchdog >= DOG_LIMIT) begin
                $display("platform_leg_length_solver_tb failed");
                $finish;
            end
            if (src_done && len_queue.size() == 0) begin
                repeat (500) @(posedge i_clk);
                if (mismatches == 0 && len_queue.size() == 0)
                    $display("platform_leg_length_solver_tb passed");
                else
                    $display("platform_leg_length_solver_tb failed");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
rtl/core/plat_pkg.sv
rtl/core/plat_ram.sv
rtl/core/plat_cordic.sv
rtl/core/plat_sqrt.sv
rtl/core/platform_leg_length_solver.sv
rtl/core/plat_checker.sv
sim/platform_leg_length_solver_tb.sv
